// File: sv/multi_reader_byte_ring_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-reader byte ring
// Shared helpers for the concurrent checks in the RTL files.
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_BYTE_RING_DEFINES_SVH
`define MULTI_READER_BYTE_RING_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MRBR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MRBR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mrbr_pkg.sv
// ----------------------------------------------------------------------------
// Multi-reader byte ring package
// Sizes, operation and status codes, and controller-datapath structs.
// ----------------------------------------------------------------------------
package mrbr_pkg;

    localparam int BufSize = 4096;
    localparam int Procs   = 8;
    localparam int PtrW    = $clog2(BufSize);
    localparam int SlotW   = $clog2(Procs);
    localparam int CntW    = $clog2(Procs + 1);
    localparam int ReclW   = 13;

    typedef enum logic [2:0] {
        FN_CREATE = 3'd0,
        FN_WRITE  = 3'd1,
        FN_READ   = 3'd2,
        FN_FLUSH  = 3'd3,
        FN_FORK   = 3'd4,
        FN_CLOSE  = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_NONE   = 3'd1,
        ST_ACCESS = 3'd2,
        ST_CLOSED = 3'd3,
        ST_OTHER  = 3'd4
    } status_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic latch;    // capture input item
        logic execute;  // evaluate and commit the operation
        logic flush_step; // examine one client for flush
        logic flush_done; // commit flush
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_flush;  // latched item is a flush that must scan
        logic last_slot; // scan index at last slot
    } stat_t;

endpackage

// File: sv/mrbr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module mrbr_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/mrbr_ctrl.sv
// ----------------------------------------------------------------------------
// Multi-reader byte ring controller
// Sequences accept, execute, flush scan and result handoff.
// ----------------------------------------------------------------------------
`include "multi_reader_byte_ring_defines.svh"

module mrbr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_load,
    input  logic                 out_free,
    input  mrbr_pkg::stat_t      stat,
    output mrbr_pkg::cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.is_flush) begin
                    state_next = S_SCAN;
                end else if (out_free) begin
                    cmd.execute = 1'b1;
                    out_load    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN: begin
                cmd.flush_step = 1'b1;
                if (stat.last_slot) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.flush_done = 1'b1;
                    out_load       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `MRBR_ASSERT_IMP(a_ready_idle, aclk, aresetn, in_ready, state_reg == S_IDLE, "ready outside idle")
    `MRBR_ASSERT_NXT(a_latch_exec, aclk, aresetn, cmd.latch, state_reg == S_EXEC, "latch not followed by execute")
    `MRBR_ASSERT_IMP(a_load_free, aclk, aresetn, out_load, out_free, "result loaded into busy register")

endmodule

// File: sv/mrbr_dpath.sv
// ----------------------------------------------------------------------------
// Multi-reader byte ring datapath
// Client table, ring pointers, byte store and result register.
// ----------------------------------------------------------------------------
`include "multi_reader_byte_ring_defines.svh"

module mrbr_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [2:0]                  func,
    input  logic [15:0]                 pid,
    input  logic [15:0]                 parent_pid,
    input  logic                        end_is_write,
    input  logic [7:0]                  data_in,
    input  mrbr_pkg::cmd_t              cmd,
    output mrbr_pkg::stat_t             stat,
    input  logic                        out_load,
    input  logic                        m_take,
    output logic                        out_free,
    output logic                        m_valid,
    output logic [2:0]                  m_status,
    output logic [7:0]                  m_data_out,
    output logic [mrbr_pkg::ReclW-1:0]  m_reclaimed,
    output logic                        m_freed
);

    localparam int P  = mrbr_pkg::Procs;
    localparam int PW = mrbr_pkg::PtrW;
    localparam int SW = mrbr_pkg::SlotW;
    localparam int CW = mrbr_pkg::CntW;
    localparam int RW = mrbr_pkg::ReclW;
    localparam logic [PW:0] BufLen = (PW + 1)'(mrbr_pkg::BufSize);
    localparam logic [PW:0] NoBest = (PW + 1)'(mrbr_pkg::BufSize);

    // Latched item.
    logic [2:0]  func_reg;
    logic [15:0] pid_reg, ppid_reg;
    logic        wend_reg;
    logic [7:0]  din_reg;

    // Ring state.
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic          rempty_reg, rfull_reg;
    logic [15:0]   cid_reg [P];
    logic [PW-1:0] crp_reg [P];
    logic          cval_reg [P], copr_reg [P], copw_reg [P], cemp_reg [P], cful_reg [P];
    logic [CW-1:0] ccnt_reg;

    // Flush scan state.
    logic [SW-1:0] scan_reg;
    logic [PW:0]   best_reg;
    logic          found_reg;

    // Result register.
    logic          mv_reg;
    logic [2:0]    st_reg;
    logic [7:0]    dout_reg;
    logic [RW-1:0] recl_reg;
    logic          freed_reg;
    logic          rd_pend_reg;

    // Lookups over the client table.
    logic          hit_c, hit_p, free_any;
    logic [SW-1:0] k_c, k_p, k_free;
    always_comb begin
        hit_c = 1'b0; hit_p = 1'b0; free_any = 1'b0;
        k_c = '0; k_p = '0; k_free = '0;
        for (int i = 0; i < P; i++) begin
            if (cval_reg[i] && cid_reg[i] == pid_reg) begin
                hit_c = 1'b1; k_c = SW'(i);
            end
            if (cval_reg[i] && cid_reg[i] == ppid_reg) begin
                hit_p = 1'b1; k_p = SW'(i);
            end
        end
        for (int i = P - 1; i >= 0; i--) begin
            if (!cval_reg[i]) begin
                free_any = 1'b1; k_free = SW'(i);
            end
        end
    end

    logic [PW-1:0] wptr_adv, rptr_k_adv;
    assign wptr_adv   = (wptr_reg == PW'(mrbr_pkg::BufSize - 1)) ? '0 : wptr_reg + 1'b1;
    assign rptr_k_adv = (crp_reg[k_c] == PW'(mrbr_pkg::BufSize - 1)) ? '0 : crp_reg[k_c] + 1'b1;

    logic has_pipe;
    assign has_pipe = (ccnt_reg != '0);

    // Operation decode.
    logic [2:0] ex_st;
    logic       do_wr, do_rd, do_create, do_fork, do_close, close_last;
    always_comb begin
        ex_st = mrbr_pkg::ST_OTHER;
        do_wr = 1'b0; do_rd = 1'b0; do_create = 1'b0; do_fork = 1'b0;
        do_close = 1'b0; close_last = 1'b0;
        if (func_reg == mrbr_pkg::FN_CREATE) begin
            do_create = 1'b1; ex_st = mrbr_pkg::ST_DONE;
        end else if (has_pipe) begin
            case (func_reg)
                mrbr_pkg::FN_WRITE: begin
                    if (!wend_reg) ex_st = mrbr_pkg::ST_ACCESS;
                    else if (!hit_c) ex_st = mrbr_pkg::ST_OTHER;
                    else if (!copw_reg[k_c]) ex_st = mrbr_pkg::ST_CLOSED;
                    else if (rfull_reg) ex_st = mrbr_pkg::ST_NONE;
                    else begin
                        ex_st = mrbr_pkg::ST_DONE; do_wr = 1'b1;
                    end
                end
                mrbr_pkg::FN_READ: begin
                    if (wend_reg) ex_st = mrbr_pkg::ST_ACCESS;
                    else if (!hit_c) ex_st = mrbr_pkg::ST_OTHER;
                    else if (!copr_reg[k_c]) ex_st = mrbr_pkg::ST_CLOSED;
                    else if (cemp_reg[k_c]) ex_st = mrbr_pkg::ST_NONE;
                    else begin
                        ex_st = mrbr_pkg::ST_DONE; do_rd = 1'b1;
                    end
                end
                mrbr_pkg::FN_FORK: begin
                    if (hit_c) ex_st = mrbr_pkg::ST_DONE;
                    else if (ccnt_reg >= CW'(P) || !hit_p || !free_any)
                        ex_st = mrbr_pkg::ST_OTHER;
                    else begin
                        ex_st = mrbr_pkg::ST_DONE; do_fork = 1'b1;
                    end
                end
                mrbr_pkg::FN_CLOSE: begin
                    if (hit_c) begin
                        ex_st = mrbr_pkg::ST_DONE; do_close = 1'b1;
                        close_last = (wend_reg ? !copr_reg[k_c] : !copw_reg[k_c])
                                     && (ccnt_reg == CW'(1));
                    end
                end
                default: ex_st = mrbr_pkg::ST_OTHER;
            endcase
        end
    end

    // Distance of the scanned client from the reclaim pointer.
    logic [PW:0] gap;
    logic        scan_ok;
    always_comb begin
        gap = {1'b0, crp_reg[scan_reg] - rptr_reg};
        if (gap == '0 && cemp_reg[scan_reg]) gap = BufLen;
        scan_ok = cval_reg[scan_reg] && copr_reg[scan_reg];
    end

    logic [PW-1:0] rptr_flush;
    assign rptr_flush = rptr_reg + best_reg[PW-1:0];
    logic          flush_commit;
    assign flush_commit = found_reg && !rempty_reg;

    assign stat.is_flush  = (func_reg == mrbr_pkg::FN_FLUSH) && has_pipe;
    assign stat.last_slot = (scan_reg == SW'(P - 1));

    // Byte store.
    logic [7:0] ram_q;
    mrbr_ram #(.Width(8), .Depth(mrbr_pkg::BufSize)) u_store (
        .aclk (aclk),
        .we   (cmd.execute && do_wr),
        .waddr(wptr_reg),
        .wdata(din_reg),
        .raddr(crp_reg[k_c]),
        .rdata(ram_q)
    );

    // Item latch (payload).
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg <= func; pid_reg <= pid; ppid_reg <= parent_pid;
            wend_reg <= end_is_write; din_reg <= data_in;
        end
    end

    // Ring and client state.
    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.execute && (do_create || close_last))) begin
            wptr_reg <= '0; rptr_reg <= '0; rempty_reg <= 1'b1; rfull_reg <= 1'b0;
            ccnt_reg <= '0;
            for (int i = 0; i < P; i++) begin
                cid_reg[i] <= '0; crp_reg[i] <= '0; cval_reg[i] <= 1'b0;
                copr_reg[i] <= 1'b0; copw_reg[i] <= 1'b0;
                cemp_reg[i] <= 1'b0; cful_reg[i] <= 1'b0;
            end
            if (aresetn && do_create) begin
                cid_reg[0] <= pid_reg; cval_reg[0] <= 1'b1; copr_reg[0] <= 1'b1;
                copw_reg[0] <= 1'b1; cemp_reg[0] <= 1'b1; ccnt_reg <= CW'(1);
            end
        end else if (cmd.execute) begin
            if (do_wr) begin
                wptr_reg <= wptr_adv; rempty_reg <= 1'b0;
                if (wptr_adv == rptr_reg) rfull_reg <= 1'b1;
                for (int i = 0; i < P; i++) begin
                    if (cval_reg[i]) begin
                        if (crp_reg[i] == wptr_adv) cful_reg[i] <= 1'b1;
                        cemp_reg[i] <= 1'b0;
                    end
                end
            end
            if (do_rd) begin
                crp_reg[k_c] <= rptr_k_adv; cful_reg[k_c] <= 1'b0;
                if (rptr_k_adv == wptr_reg) cemp_reg[k_c] <= 1'b1;
            end
            if (do_fork) begin
                cid_reg[k_free] <= pid_reg; crp_reg[k_free] <= crp_reg[k_p];
                cval_reg[k_free] <= cval_reg[k_p]; copr_reg[k_free] <= copr_reg[k_p];
                copw_reg[k_free] <= copw_reg[k_p]; cemp_reg[k_free] <= cemp_reg[k_p];
                cful_reg[k_free] <= cful_reg[k_p];
                ccnt_reg <= ccnt_reg + 1'b1;
            end
            if (do_close) begin
                if (wend_reg) copw_reg[k_c] <= 1'b0;
                else copr_reg[k_c] <= 1'b0;
                if (wend_reg ? !copr_reg[k_c] : !copw_reg[k_c]) begin
                    cval_reg[k_c] <= 1'b0; copr_reg[k_c] <= 1'b0; copw_reg[k_c] <= 1'b0;
                    cemp_reg[k_c] <= 1'b0; cful_reg[k_c] <= 1'b0;
                    ccnt_reg <= ccnt_reg - 1'b1;
                end
            end
        end else if (cmd.flush_done && flush_commit) begin
            rptr_reg <= rptr_flush;
            if (best_reg != '0) begin
                rfull_reg <= 1'b0;
                if (rptr_flush == wptr_reg) rempty_reg <= 1'b1;
            end
        end
    end

    // Flush scan: one client per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.latch) begin
            scan_reg <= '0; best_reg <= NoBest; found_reg <= 1'b0;
        end else if (cmd.flush_step) begin
            scan_reg <= scan_reg + 1'b1;
            if (scan_ok) begin
                found_reg <= 1'b1;
                if (gap < best_reg) best_reg <= gap;
            end
        end
    end

    // Result register; a read's byte lands in the cycle after execute.
    assign out_free = !mv_reg || m_take;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0; rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.execute && do_rd;
            if (out_load) mv_reg <= 1'b1;
            else if (m_take) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_pend_reg) dout_reg <= ram_q;
        if (cmd.execute) begin
            st_reg <= ex_st; dout_reg <= '0; recl_reg <= '0;
            freed_reg <= close_last;
        end else if (cmd.flush_done) begin
            st_reg <= mrbr_pkg::ST_DONE; dout_reg <= '0; freed_reg <= 1'b0;
            recl_reg <= flush_commit ? RW'(best_reg) : '0;
        end
    end

    assign m_valid     = mv_reg && !rd_pend_reg;
    assign m_status    = st_reg;
    assign m_data_out  = dout_reg;
    assign m_reclaimed = recl_reg;
    assign m_freed     = freed_reg;

    `MRBR_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, ccnt_reg <= CW'(P), "client count overflow")
    `MRBR_ASSERT_IMP(a_full_empty, aclk, aresetn, rfull_reg, !rempty_reg, "ring full and empty")
    `MRBR_ASSERT_NXT(a_freed_reset, aclk, aresetn, cmd.execute && close_last, ccnt_reg == '0, "freed without reset")

endmodule

// File: sv/multi_reader_byte_ring.sv
// ----------------------------------------------------------------------------
// Multi-reader byte ring
// A byte ring with per-client read pointers, shared by up to eight clients.
// ----------------------------------------------------------------------------
// Usage: each slave-side transaction carries one operation (create, write a
// byte, read a byte, flush, fork or close) and yields exactly one master-side
// transaction with status, read byte, reclaimed count and freed flag.
// Items are handled one at a time. A non-flush item is latched on acceptance,
// evaluated in the execute state and registered into the result register; a
// read result also waits for the registered store read. A new item is accepted
// only after the controller has returned to idle. A flush scans the client
// table one slot per cycle between the execute and finish states, and its
// result waits in the finish state until the output register is free.
// A stalled receiver holds the result in the output register; one more item
// is accepted and then waits, and the input stalls until that register frees.
// Reset (aresetn low, synchronous) clears pointers, flags and the client
// table; the byte store has no clearing pass and holds whatever was written.
// ----------------------------------------------------------------------------
module multi_reader_byte_ring (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: func[2:0], pid[18:3], parent_pid[34:19], end_is_write[35],
    // data_in[43:36], zero fill [47:44]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[2:0], data_out[10:3], reclaimed[23:11], freed[24],
    // zero fill [31:25]
    output logic [31:0] m_tdata
);

    mrbr_pkg::cmd_t  cmd;
    mrbr_pkg::stat_t stat;
    logic            out_load, out_free, mv;
    logic [2:0]      st;
    logic [7:0]      dout;
    logic [mrbr_pkg::ReclW-1:0] recl;
    logic            freed;

    mrbr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .out_load(out_load),
        .out_free(out_free),
        .stat    (stat),
        .cmd     (cmd)
    );

    mrbr_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .func        (s_tdata[2:0]),
        .pid         (s_tdata[18:3]),
        .parent_pid  (s_tdata[34:19]),
        .end_is_write(s_tdata[35]),
        .data_in     (s_tdata[43:36]),
        .cmd         (cmd),
        .stat        (stat),
        .out_load    (out_load),
        .m_take      (mv && m_tready),
        .out_free    (out_free),
        .m_valid     (mv),
        .m_status    (st),
        .m_data_out  (dout),
        .m_reclaimed (recl),
        .m_freed     (freed)
    );

    assign m_tvalid = mv;
    assign m_tdata  = {7'd0, freed, recl, dout, st};

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Multi-reader byte ring testbench
// Drives create, write, read, flush, fork and close operations into the ring
// and checks every result transaction against a cycle-free model of the
// client table and the ring. A directed opening covers the corner cases, and
// the random part is built from pipe sessions.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes outside the defined operation set.
    localparam logic [2:0] FN_UNUSED_6 = 3'd6;
    localparam logic [2:0] FN_UNUSED_7 = 3'd7;
    localparam int TOTAL_ITEMS = 1850;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [2:0]  func;
        logic [15:0] pid;
        logic [15:0] parent_pid;
        logic        end_is_write;
        logic [7:0]  data_in;
    } op_t;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  data_out;
        logic [12:0] reclaimed;
        logic        freed;
    } outcome_t;

    // Scoreboard: ring model plus the queue of outcomes still to arrive.
    class ring_scoreboard;
        logic [7:0]  ring_mem [mrbr_pkg::BufSize];
        int          wr_ptr;
        int          recl_ptr;
        bit          is_empty;
        bit          is_full;
        logic [15:0] owner [mrbr_pkg::Procs];
        int          rd_ptr [mrbr_pkg::Procs];
        bit          used [mrbr_pkg::Procs];
        bit          rd_open [mrbr_pkg::Procs];
        bit          wr_open [mrbr_pkg::Procs];
        bit          c_empty [mrbr_pkg::Procs];
        bit          c_full [mrbr_pkg::Procs];
        int          clients;
        outcome_t    pending [$];
        int          mismatches;
        int          results_seen;
        int          flush_bytes;
        int          frees;

        function void clear_ring();
            wr_ptr = 0;
            recl_ptr = 0;
            is_empty = 1;
            is_full = 0;
            clients = 0;
            for (int i = 0; i < mrbr_pkg::Procs; i++) begin
                owner[i] = '0;
                rd_ptr[i] = 0;
                used[i] = 0;
                rd_open[i] = 0;
                wr_open[i] = 0;
                c_empty[i] = 0;
                c_full[i] = 0;
            end
        endfunction

        // The highest valid slot wins when several ids match.
        function int lookup(logic [15:0] id);
            int hit;
            hit = -1;
            for (int i = 0; i < mrbr_pkg::Procs; i++)
                if (used[i] && owner[i] == id) hit = i;
            return hit;
        endfunction

        function int step(int p);
            return (p + 1 >= mrbr_pkg::BufSize) ? 0 : p + 1;
        endfunction

        function int ring_flush();
            int best;
            int d;
            best = mrbr_pkg::BufSize + 1;
            if (is_empty) return 0;
            for (int i = 0; i < mrbr_pkg::Procs; i++) begin
                if (!(used[i] && rd_open[i])) continue;
                d = (rd_ptr[i] + mrbr_pkg::BufSize - recl_ptr) % mrbr_pkg::BufSize;
                if (d == 0 && c_empty[i]) d = mrbr_pkg::BufSize;
                if (d < best) best = d;
            end
            if (best > mrbr_pkg::BufSize) return 0;
            recl_ptr = (recl_ptr + best) % mrbr_pkg::BufSize;
            if (best != 0) begin
                is_full = 0;
                if (recl_ptr == wr_ptr) is_empty = 1;
            end
            return best;
        endfunction

        // Works out the outcome of one accepted operation.
        function void note_input(op_t op);
            outcome_t o;
            int k;
            o = '{status: mrbr_pkg::ST_OTHER, data_out: 8'd0, reclaimed: 13'd0,
                  freed: 1'b0};
            if (op.func == mrbr_pkg::FN_CREATE) begin
                clear_ring();
                owner[0] = op.pid;
                used[0] = 1;
                rd_open[0] = 1;
                wr_open[0] = 1;
                c_empty[0] = 1;
                clients = 1;
                o.status = mrbr_pkg::ST_DONE;
            end else if (op.func <= mrbr_pkg::FN_CLOSE && clients != 0) begin
                k = lookup(op.pid);
                case (op.func)
                    mrbr_pkg::FN_WRITE: begin
                        if (!op.end_is_write) o.status = mrbr_pkg::ST_ACCESS;
                        else if (k < 0) o.status = mrbr_pkg::ST_OTHER;
                        else if (!wr_open[k]) o.status = mrbr_pkg::ST_CLOSED;
                        else if (is_full) o.status = mrbr_pkg::ST_NONE;
                        else begin
                            ring_mem[wr_ptr] = op.data_in;
                            wr_ptr = step(wr_ptr);
                            is_empty = 0;
                            if (wr_ptr == recl_ptr) is_full = 1;
                            for (int i = 0; i < mrbr_pkg::Procs; i++) begin
                                if (!used[i]) continue;
                                if (rd_ptr[i] == wr_ptr) c_full[i] = 1;
                                c_empty[i] = 0;
                            end
                            o.status = mrbr_pkg::ST_DONE;
                        end
                    end
                    mrbr_pkg::FN_READ: begin
                        if (op.end_is_write) o.status = mrbr_pkg::ST_ACCESS;
                        else if (k < 0) o.status = mrbr_pkg::ST_OTHER;
                        else if (!rd_open[k]) o.status = mrbr_pkg::ST_CLOSED;
                        else if (c_empty[k]) o.status = mrbr_pkg::ST_NONE;
                        else begin
                            o.data_out = ring_mem[rd_ptr[k]];
                            rd_ptr[k] = step(rd_ptr[k]);
                            c_full[k] = 0;
                            if (rd_ptr[k] == wr_ptr) c_empty[k] = 1;
                            o.status = mrbr_pkg::ST_DONE;
                        end
                    end
                    mrbr_pkg::FN_FLUSH: begin
                        o.reclaimed = 13'(ring_flush());
                        flush_bytes += o.reclaimed;
                        o.status = mrbr_pkg::ST_DONE;
                    end
                    mrbr_pkg::FN_FORK: begin
                        int par;
                        par = lookup(op.parent_pid);
                        if (k >= 0) o.status = mrbr_pkg::ST_DONE;
                        else if (clients >= mrbr_pkg::Procs || par < 0)
                            o.status = mrbr_pkg::ST_OTHER;
                        else begin
                            for (int i = 0; i < mrbr_pkg::Procs; i++) begin
                                if (!used[i]) begin
                                    used[i] = 1;
                                    rd_open[i] = rd_open[par];
                                    wr_open[i] = wr_open[par];
                                    c_empty[i] = c_empty[par];
                                    c_full[i] = c_full[par];
                                    rd_ptr[i] = rd_ptr[par];
                                    owner[i] = op.pid;
                                    clients++;
                                    break;
                                end
                            end
                            o.status = mrbr_pkg::ST_DONE;
                        end
                    end
                    default: begin
                        if (k >= 0) begin
                            if (op.end_is_write) wr_open[k] = 0;
                            else rd_open[k] = 0;
                            if (!rd_open[k] && !wr_open[k]) begin
                                used[k] = 0;
                                c_empty[k] = 0;
                                c_full[k] = 0;
                                clients--;
                            end
                            if (clients == 0) begin
                                clear_ring();
                                o.freed = 1;
                                frees++;
                            end
                            o.status = mrbr_pkg::ST_DONE;
                        end
                    end
                endcase
            end
            pending.push_back(o);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compares one result transaction with the oldest outcome waiting.
        task check_result(logic [31:0] tdata);
            outcome_t w;
            results_seen++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", tdata));
                return;
            end
            w = pending.pop_front();
            if (tdata[2:0] !== w.status)
                report($sformatf("status %0d, want %0d", tdata[2:0], w.status));
            if (tdata[10:3] !== w.data_out)
                report($sformatf("data_out %h, want %h", tdata[10:3], w.data_out));
            if (tdata[23:11] !== w.reclaimed)
                report($sformatf("reclaimed %0d, want %0d", tdata[23:11], w.reclaimed));
            if (tdata[24] !== w.freed)
                report($sformatf("freed %b, want %b", tdata[24], w.freed));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;

    ring_scoreboard sb;
    bit          quiet = 0;
    bit          hold_req = 0;
    int          ops_sent = 0;
    logic [15:0] pool [$];

    multi_reader_byte_ring dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Offers one operation and waits until it is accepted.
    task send(logic [2:0] func, logic [15:0] pid, logic [15:0] ppid, logic wr,
              logic [7:0] data);
        op_t op;
        op = '{func, pid, ppid, wr, data};
        while (!quiet && $urandom_range(99) < 13) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'b0, data, wr, ppid, pid, func};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op);
        ops_sent++;
    endtask

    function logic [15:0] pick_pid();
        if (pool.size() == 0 || $urandom_range(99) < 8) return 16'($urandom);
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    // Accepts results, with random stalls and one long hold-off.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
                m_tready <= 0;
            end else begin
                m_tready <= aresetn && (quiet || $urandom_range(99) >= 13);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int r;
        bit held;
        logic [15:0] p;
        sb = new();
        sb.clear_ring();
        held = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed opening: extremes, every operation, and the error cases.
        send(mrbr_pkg::FN_CLOSE, 16'h0001, 16'h0, 1'b1, 8'h00);       // no pipe yet
        send(mrbr_pkg::FN_CREATE, 16'hFFFF, 16'h0, 1'b0, 8'h00);
        send(mrbr_pkg::FN_WRITE, 16'hFFFF, 16'h0, 1'b1, 8'hFF);
        send(mrbr_pkg::FN_WRITE, 16'hFFFF, 16'h0, 1'b1, 8'h00);
        send(mrbr_pkg::FN_WRITE, 16'hFFFF, 16'h0, 1'b0, 8'h5A);       // wrong end
        send(mrbr_pkg::FN_READ, 16'hFFFF, 16'h0, 1'b1, 8'h00);        // wrong end
        send(mrbr_pkg::FN_READ, 16'h1234, 16'h0, 1'b0, 8'h00);        // unknown caller
        send(mrbr_pkg::FN_FORK, 16'h0000, 16'hFFFF, 1'b0, 8'h00);
        send(mrbr_pkg::FN_FORK, 16'h0000, 16'hFFFF, 1'b1, 8'h00);     // child exists
        send(mrbr_pkg::FN_FORK, 16'h0007, 16'hABCD, 1'b0, 8'h00);     // parent missing
        send(mrbr_pkg::FN_READ, 16'hFFFF, 16'h0, 1'b0, 8'h00);
        send(mrbr_pkg::FN_READ, 16'hFFFF, 16'h0, 1'b0, 8'h00);
        send(mrbr_pkg::FN_READ, 16'hFFFF, 16'h0, 1'b0, 8'h00);        // reader empty
        send(mrbr_pkg::FN_FLUSH, 16'h0, 16'h0, 1'b0, 8'h00);          // child holds it
        send(mrbr_pkg::FN_READ, 16'h0000, 16'h0, 1'b0, 8'h00);
        send(mrbr_pkg::FN_CLOSE, 16'h0000, 16'h0, 1'b1, 8'h00);
        send(mrbr_pkg::FN_WRITE, 16'h0000, 16'h0, 1'b1, 8'h11);       // end closed
        send(mrbr_pkg::FN_FLUSH, 16'h0, 16'h0, 1'b1, 8'h00);
        send(FN_UNUSED_6, 16'hFFFF, 16'h0, 1'b0, 8'h00);
        send(FN_UNUSED_7, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
        send(mrbr_pkg::FN_CLOSE, 16'h0000, 16'h0, 1'b0, 8'h00);
        send(mrbr_pkg::FN_CLOSE, 16'hFFFF, 16'h0, 1'b0, 8'h00);
        send(mrbr_pkg::FN_READ, 16'hFFFF, 16'h0, 1'b0, 8'h00);        // read end closed
        send(mrbr_pkg::FN_CLOSE, 16'hFFFF, 16'h0, 1'b1, 8'h00);       // last one: freed
        send(mrbr_pkg::FN_FLUSH, 16'h0, 16'h0, 1'b0, 8'h00);          // no pipe

        // Random sessions: create, then a mix of traffic from the clients.
        while (ops_sent < TOTAL_ITEMS) begin
            pool.delete();
            p = 16'($urandom);
            pool.push_back(p);
            send(mrbr_pkg::FN_CREATE, p, 16'($urandom), 1'($urandom), 8'($urandom));
            for (int j = $urandom_range(120, 20); j > 0 && ops_sent < TOTAL_ITEMS; j--) begin
                if (!held && ops_sent >= 300) begin
                    hold_req = 1;
                    held = 1;
                end
                quiet = (ops_sent >= 800 && ops_sent < 1100);
                r = $urandom_range(99);
                if (r < 30) begin
                    send(mrbr_pkg::FN_WRITE, pick_pid(), 16'($urandom),
                         $urandom_range(99) < 95, 8'($urandom));
                end else if (r < 55) begin
                    send(mrbr_pkg::FN_READ, pick_pid(), 16'($urandom),
                         $urandom_range(99) < 5, 8'($urandom));
                end else if (r < 63) begin
                    send(mrbr_pkg::FN_FLUSH, 16'($urandom), 16'($urandom), 1'($urandom),
                         8'($urandom));
                end else if (r < 75) begin
                    p = 16'($urandom);
                    send(mrbr_pkg::FN_FORK, p, pick_pid(), 1'($urandom), 8'($urandom));
                    pool.push_back(p);
                end else if (r < 82) begin
                    send(mrbr_pkg::FN_CLOSE, pick_pid(), 16'($urandom), 1'($urandom),
                         8'($urandom));
                end else if (r < 86) begin
                    send($urandom_range(1) ? FN_UNUSED_6 : FN_UNUSED_7,
                         16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
                end else begin
                    // Burst of writes from one client.
                    p = pick_pid();
                    for (int b = $urandom_range(40, 5); b > 0; b--)
                        send(mrbr_pkg::FN_WRITE, p, 16'h0, 1'b1, 8'($urandom));
                end
            end
            // Often wind the session down so the pipe is freed.
            if ($urandom_range(99) < 45) begin
                foreach (pool[i]) begin
                    send(mrbr_pkg::FN_CLOSE, pool[i], 16'h0, 1'b0, 8'h00);
                    send(mrbr_pkg::FN_CLOSE, pool[i], 16'h0, 1'b1, 8'h00);
                end
                send(mrbr_pkg::FN_WRITE, pool[0], 16'h0, 1'b1, 8'h77);
            end
        end
        quiet = 0;
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        $display("Run covered %0d operations and %0d results, %0d bytes reclaimed,",
                 ops_sent, sb.results_seen, sb.flush_bytes);
        $display("%0d pipe frees, one long receiver hold-off, %0d mismatches.",
                 sb.frees, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
